// ===== rtl/rtps_pkg.sv =====
// Package for the reduction thread partition search: types, widths and divider interface.
package rtps_pkg;

  localparam int ThrW  = 10;
  localparam int JobW  = 16;
  localparam int JszW  = 24;
  localparam int RedW  = 16;
  localparam int BufW  = 40;
  localparam int DivW  = 40;
  localparam int CostW = 64;

  localparam logic [0:0] CfgBufLimit   = 1'b0;
  localparam logic [0:0] CfgAllowSplit = 1'b1;

  localparam logic [BufW-1:0] BufLimitReset = 40'd1048576;

  typedef enum logic [3:0] {
    StIdle,
    StMinJpg,
    StMaxJpg,
    StInitGrp,
    StCandGrp,
    StTpg,
    StBound,
    StRedCeil,
    StCost1,
    StCost2,
    StCompare,
    StDone
  } state_e;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/reduction_thread_partition_search_core.sv =====
// Top level of the reduction thread partition search: sequencer around a shared divider.
//
// channel   | direction | handshake              | payload
// s_axis    | in        | s_axis_tvalid/tready   | thread_count, job_count, job_size, red_len
// m_axis    | out       | m_axis_tvalid/tready   | group_count, threads_per_group, bound, status
// cfg       | in        | cfg_valid_i/cfg_ready_o| register index, write data
//
// Every division runs on the one shared divider. The two setup divisions and the three
// for the starting choice come before the first candidate. Each candidate takes four
// divisions and three steps, or three divisions when the buffer bound skips it; candidates
// run from max(1, jobs/threads) up to job_count - 1.
// Zero-input requests give a result the cycle after acceptance.
// Reset restores the register defaults.
// The input is not ready until the result has been taken on m_axis.
module reduction_thread_partition_search_core import rtps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [9:0] thread_count, [25:10] job_count, [49:26] job_size, [65:50] reduction_length
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [9:0] group_count, [19:10] threads_per_group, [35:20] jobs_per_group_bound
  output logic [39:0] m_axis_tdata,
  // [0] status
  output logic        m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [39:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [BufW-1:0]  buf_limit_q;
  logic             allow_split_q;
  logic [ThrW-1:0]  thr_q;
  logic [JobW-1:0]  jobs_q;
  logic [JszW-1:0]  jsz_q;
  logic [RedW-1:0]  red_q;
  logic [JobW-1:0]  cand_q, cand_d;
  logic [BufW-1:0]  max_jpg_q, max_jpg_d;
  logic [ThrW-1:0]  cg_q, cg_d;
  logic [ThrW-1:0]  ct_q, ct_d;
  logic [JobW-1:0]  cb_q, cb_d;
  logic [RedW:0]    rc_q, rc_d;
  logic [CostW-1:0] prod_q, prod_d;
  logic [CostW-1:0] best_q, best_d;
  logic [ThrW-1:0]  bg_q, bg_d;
  logic [ThrW-1:0]  bt_q, bt_d;
  logic [JobW-1:0]  bb_q, bb_d;
  logic             init_q, init_d;
  logic             out_valid_q, out_valid_d;
  logic             status_q, status_d;
  logic             load;

  div_req_t div_req;
  div_rsp_t div_rsp;

  rtps_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready = (state_q == StIdle) && !out_valid_q;
  assign load          = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  logic [ThrW-1:0] in_thr;
  logic [JobW-1:0] in_jobs;
  logic [JszW-1:0] in_jsz;
  logic [RedW-1:0] in_red;
  assign in_thr  = s_axis_tdata[9:0];
  assign in_jobs = s_axis_tdata[25:10];
  assign in_jsz  = s_axis_tdata[49:26];
  assign in_red  = s_axis_tdata[65:50];

  // Helpers on the divider result
  logic [DivW-1:0] q;
  logic [ThrW-1:0] grp_of_q;
  logic [ThrW-1:0] tpg_of_q;
  assign q        = div_rsp.quotient;
  assign grp_of_q = (q > DivW'(thr_q)) ? thr_q : q[ThrW-1:0];
  assign tpg_of_q = (q > DivW'(red_q)) ? ThrW'(red_q) : q[ThrW-1:0];

  // Sequence the search
  always_comb begin
    state_d     = state_q;
    cand_d      = cand_q;
    max_jpg_d   = max_jpg_q;
    cg_d        = cg_q;
    ct_d        = ct_q;
    cb_d        = cb_q;
    rc_d        = rc_q;
    prod_d      = prod_q;
    best_d      = best_q;
    bg_d        = bg_q;
    bt_d        = bt_q;
    bb_d        = bb_q;
    init_d      = init_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    div_req     = '0;
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (load) begin
          if (in_thr == '0 || in_jobs == '0 || in_jsz == '0 || in_red == '0) begin
            status_d    = 1'b1;
            bg_d        = '0;
            bt_d        = '0;
            bb_d        = '0;
            out_valid_d = 1'b1;
          end else begin
            status_d         = 1'b0;
            div_req.start    = 1'b1;
            div_req.dividend = DivW'(in_jobs);
            div_req.divisor  = DivW'(in_thr);
            state_d          = StMinJpg;
          end
        end
      end
      StMinJpg: begin
        if (div_rsp.done) begin
          cand_d           = (q == '0) ? JobW'(1) : q[JobW-1:0];
          div_req.start    = 1'b1;
          div_req.dividend = buf_limit_q;
          div_req.divisor  = DivW'(thr_q) * DivW'(jsz_q);
          state_d          = StMaxJpg;
        end
      end
      StMaxJpg: begin
        if (div_rsp.done) begin
          max_jpg_d        = (q == '0) ? BufW'(1) : q;
          div_req.start    = 1'b1;
          div_req.dividend = DivW'(jobs_q);
          div_req.divisor  = DivW'(cand_q);
          init_d           = 1'b1;
          best_d           = CostW'(jobs_q) * CostW'(jsz_q);
          state_d          = StCandGrp;
        end
      end
      StInitGrp: begin
        // Start group division for the current candidate, or end the search once it reaches the job count
        if (cand_q >= jobs_q) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DivW'(jobs_q);
          div_req.divisor  = DivW'(cand_q);
          state_d          = StCandGrp;
        end
      end
      StCandGrp: begin
        if (div_rsp.done) begin
          cg_d             = grp_of_q;
          div_req.start    = 1'b1;
          div_req.dividend = DivW'(thr_q);
          div_req.divisor  = DivW'(grp_of_q);
          state_d          = StTpg;
        end
      end
      StTpg: begin
        if (div_rsp.done) begin
          ct_d             = allow_split_q ? tpg_of_q : ThrW'(1);
          div_req.start    = 1'b1;
          div_req.dividend = DivW'(jobs_q) + DivW'(cg_q) - DivW'(1);
          div_req.divisor  = DivW'(cg_q);
          state_d          = StBound;
        end
      end
      StBound: begin
        if (div_rsp.done) begin
          cb_d = q[JobW-1:0];
          if (init_q) begin
            bg_d    = cg_q;
            bt_d    = ct_q;
            bb_d    = q[JobW-1:0];
            init_d  = 1'b0;
            prod_d  = best_q;
            state_d = StCost1;
          end else if (ct_q > ThrW'(1) && DivW'(q[JobW-1:0]) > max_jpg_q) begin
            cand_d  = cand_q + JobW'(1);
            state_d = StInitGrp;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = DivW'(red_q) + DivW'(ct_q) - DivW'(1);
            div_req.divisor  = DivW'(ct_q);
            state_d          = StRedCeil;
          end
        end
      end
      StRedCeil: begin
        if (div_rsp.done) begin
          rc_d    = (RedW+1)'(q[RedW-1:0]) + ((ct_q != ThrW'(1)) ? 17'd1 : 17'd0);
          prod_d  = CostW'(jsz_q) * CostW'(cb_q);
          state_d = StCost2;
        end
      end
      StCost1: begin
        // Starting cost: jobs * jsz already held, scale by reduction length
        best_d  = CostW'(prod_q[JobW+JszW-1:0]) * CostW'(red_q);
        state_d = StInitGrp;
      end
      StCost2: begin
        prod_d  = CostW'(prod_q[JobW+JszW-1:0]) * CostW'(rc_q);
        state_d = StCompare;
      end
      StCompare: begin
        if (prod_q < best_q) begin
          best_d = prod_q;
          bg_d   = cg_q;
          bt_d   = ct_q;
          bb_d   = cb_q;
        end
        cand_d  = cand_q + JobW'(1);
        state_d = StInitGrp;
      end
      StDone: begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      out_valid_q   <= 1'b0;
      init_q        <= 1'b0;
      buf_limit_q   <= BufLimitReset;
      allow_split_q <= 1'b1;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      init_q      <= init_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgBufLimit:   buf_limit_q   <= cfg_data_i;
          CfgAllowSplit: allow_split_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // Hold the payload and search registers
  always_ff @(posedge clk_i) begin
    if (load) begin
      thr_q  <= in_thr;
      jobs_q <= in_jobs;
      jsz_q  <= in_jsz;
      red_q  <= in_red;
    end
    cand_q    <= cand_d;
    max_jpg_q <= max_jpg_d;
    cg_q      <= cg_d;
    ct_q      <= ct_d;
    cb_q      <= cb_d;
    rc_q      <= rc_d;
    prod_q    <= prod_d;
    best_q    <= best_d;
    bg_q      <= bg_d;
    bt_q      <= bt_d;
    bb_q      <= bb_d;
    status_q  <= status_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, bb_q, bt_q, bg_q};
  assign m_axis_tuser  = status_q;

  // Input is never taken while a result waits
  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result pending");

  // Divider is only started when idle
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy) else $error("divider restarted while busy");

  // A result appears only out of the search or a rejected request
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == StInitGrp || $past(state_q) == StIdle)
    else $error("result raised from unexpected state");

endmodule

// ===== rtl/rtps_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
module rtps_divider import rtps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CntW = $clog2(DivW + 1);

  logic [DivW-1:0] quo_q, quo_d;
  logic [DivW-1:0] rem_q, rem_d;
  logic [DivW-1:0] dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DivW:0]   trial;

  // Load the operands on start; while busy, shift one dividend bit into the remainder and try a subtract
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[DivW-1]} - {1'b0, dvs_q};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = CntW'(DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial[DivW]) begin
        rem_d = {rem_q[DivW-2:0], quo_q[DivW-1]};
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end else begin
        rem_d = trial[DivW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== sim/tb_reduction_thread_partition_search_core.sv =====
// Testbench for the reduction thread partition search core: directed and random requests.
module tb_reduction_thread_partition_search_core;
  import rtps_pkg::*;

  localparam longint unsigned CycleLimit = 64'd6000000;

  typedef struct packed {
    logic [ThrW-1:0] group_count;
    logic [ThrW-1:0] threads_per_group;
    logic [JobW-1:0] bound;
    logic            status;
  } partition_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = '0;
  logic [39:0] cfg_data_i = '0;

  // Shadow registers and queue of partitions still to come out
  logic [BufW-1:0] buf_limit_q;
  logic            split_q;
  partition_t      partition_q[$];
  int unsigned     mismatches = 0;
  longint unsigned cycles = 0;
  int unsigned     burst_left = 0;

  reduction_thread_partition_search_core u_top (.*);

  always #1 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** reduction_thread_partition_search_core: FAILED **");
      $finish;
    end
  end

  function automatic longint unsigned ceil_q(longint unsigned a, longint unsigned b);
    return (a + b - 1) / b;
  endfunction

  function automatic longint unsigned threads_for(longint unsigned thr, longint unsigned grp,
                                                  longint unsigned red);
    longint unsigned t;
    if (!split_q) return 1;
    t = thr / grp;
    return (t < red) ? t : red;
  endfunction

  // Search all jobs-per-group candidates for the cheapest partition
  function automatic partition_t search_partition(logic [ThrW-1:0] thr_f,
                                                  logic [JobW-1:0] jobs_f,
                                                  logic [JszW-1:0] jsz_f,
                                                  logic [RedW-1:0] red_f);
    partition_t p;
    longint unsigned thr, jobs, jsz, red, min_jpg, max_jpg;
    longint unsigned grp, tpg, bnd, best, c, cg, ct, cb, cost;
    thr = thr_f; jobs = jobs_f; jsz = jsz_f; red = red_f;
    p = '0;
    if (thr == 0 || jobs == 0 || jsz == 0 || red == 0) begin
      p.status = 1'b1;
      return p;
    end
    min_jpg = jobs / thr;
    if (min_jpg < 1) min_jpg = 1;
    max_jpg = buf_limit_q / (thr * jsz);
    if (max_jpg < 1) max_jpg = 1;
    grp = jobs / min_jpg;
    if (grp > thr) grp = thr;
    tpg = threads_for(thr, grp, red);
    bnd = ceil_q(jobs, grp);
    best = jobs * jsz * red;
    for (c = min_jpg; c < jobs; c++) begin
      cg = jobs / c;
      if (cg > thr) cg = thr;
      ct = threads_for(thr, cg, red);
      cb = ceil_q(jobs, cg);
      if (!(ct > 1 && cb > max_jpg)) begin
        cost = jsz * cb * (ceil_q(red, ct) + ((ct != 1) ? 1 : 0));
        if (cost < best) begin
          grp = cg; tpg = ct; bnd = cb; best = cost;
        end
      end
    end
    p.group_count = grp[ThrW-1:0];
    p.threads_per_group = tpg[ThrW-1:0];
    p.bound = bnd[JobW-1:0];
    return p;
  endfunction

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // Receiver stall pattern: alternating phases of steady, sparse and random ready
  always @(posedge clk_i) begin
    case ((cycles >> 9) % 3)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready <= $urandom_range(0, 1);
    endcase
  end

  // Compare every result transaction with the oldest expectation
  always @(posedge clk_i) begin
    partition_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (partition_q.size() == 0) begin
        report("unexpected result transaction", 1, 0);
      end else begin
        want = partition_q.pop_front();
        if (m_axis_tdata[9:0] !== want.group_count)
          report("group_count", m_axis_tdata[9:0], want.group_count);
        if (m_axis_tdata[19:10] !== want.threads_per_group)
          report("threads_per_group", m_axis_tdata[19:10], want.threads_per_group);
        if (m_axis_tdata[35:20] !== want.bound)
          report("jobs_per_group_bound", m_axis_tdata[35:20], want.bound);
        if (m_axis_tuser !== want.status)
          report("status", m_axis_tuser, want.status);
      end
    end
  end

  // Send one request, with bursts and random gaps in front
  task automatic send_request(logic [ThrW-1:0] thr, logic [JobW-1:0] jobs,
                              logic [JszW-1:0] jsz, logic [RedW-1:0] red);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 6);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, red, jsz, jobs, thr};
    do @(posedge clk_i); while (!s_axis_tready);
    partition_q.push_back(search_partition(thr, jobs, jsz, red));
  endtask

  // Hold until every result has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (partition_q.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  // Write a register while the core is idle
  task automatic write_reg(logic [0:0] idx, logic [39:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgBufLimit) buf_limit_q = value;
    else split_q = value[0];
  endtask

  task automatic send_random();
    logic [ThrW-1:0] thr;
    logic [JobW-1:0] jobs;
    logic [JszW-1:0] jsz;
    logic [RedW-1:0] red;
    int unsigned r;
    r = $urandom_range(0, 99);
    thr = $urandom_range(1, 1023);
    jobs = $urandom_range(1, 48);
    jsz = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(1, 64);
    red = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(1, 40);
    // Single thread: no candidates, so any job count is cheap
    if (r < 10) begin
      thr = 1;
      jobs = $urandom;
    end
    if (r >= 95) begin
      case ($urandom_range(0, 3))
        0: thr = 0;
        1: jobs = 0;
        2: jsz = 0;
        default: red = 0;
      endcase
    end
    send_request(thr, jobs, jsz, red);
  endtask

  task automatic test_zero_inputs();
    send_request(0, 5, 3, 7);
    send_request(4, 0, 3, 7);
    send_request(4, 5, 0, 7);
    send_request(4, 5, 3, 0);
    send_request(0, 0, 0, 0);
  endtask

  task automatic test_extremes();
    send_request(1, 16'hFFFF, 24'hFFFFFF, 16'hFFFF);
    send_request(10'd1023, 1, 24'hFFFFFF, 16'hFFFF);
    send_request(10'd1023, 40, 1, 16'hFFFF);
    send_request(7, 50, 3, 9);
    send_request(16, 64, 2, 5);
    send_request(10'd1023, 10'd1023, 1, 1);
    send_request(3, 30, 24'hFFFFFF, 1);
  endtask

  task automatic test_buffer_limit();
    write_reg(CfgBufLimit, 40'd0);
    send_request(8, 40, 5, 100);
    send_request(2, 20, 1, 16'hFFFF);
    write_reg(CfgBufLimit, 40'hFF_FFFF_FFFF);
    send_request(8, 40, 5, 100);
    send_request(10'd1023, 48, 24'hFFFFFF, 16'hFFFF);
    write_reg(CfgBufLimit, 40'd1);
    send_request(8, 40, 5, 100);
  endtask

  task automatic test_no_split();
    write_reg(CfgAllowSplit, 40'd0);
    send_request(8, 40, 5, 100);
    send_request(10'd1023, 30, 2, 16'hFFFF);
    write_reg(CfgAllowSplit, 40'd1);
  endtask

  task automatic test_random(int unsigned n);
    repeat (n) send_random();
  endtask

  initial begin
    buf_limit_q = BufLimitReset;
    split_q = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_inputs();
    test_extremes();
    test_buffer_limit();
    test_no_split();
    write_reg(CfgBufLimit, BufLimitReset);
    test_random(35);
    // Pause until all results are out, then resume
    drain();
    test_random(5);
    write_reg(CfgAllowSplit, 40'd0);
    write_reg(CfgBufLimit, 40'd1000);
    test_random(30);
    write_reg(CfgAllowSplit, 40'd1);
    test_random(30);
    drain();
    if (mismatches == 0 && partition_q.size() == 0) begin
      $display("** reduction_thread_partition_search_core: PASSED **");
    end else begin
      $display("** reduction_thread_partition_search_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rtps_pkg.sv
rtl/rtps_divider.sv
rtl/reduction_thread_partition_search_core.sv
sim/tb_reduction_thread_partition_search_core.sv
